### rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared beat types, status codes and register map of the voxel splatter.
// ----------------------------------------------------------------------------
`default_nettype none

package tvs_pkg;

    localparam int unsigned PADDR_W = 4;

    localparam logic [31:0] INV_CELL_RESET = 32'h0001_0000;

    localparam logic KIND_SPLAT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_SPLAT   = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_READ    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_ORIGIN_Z = 2'd2,
        REG_INV_CELL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [31:0] density;
        logic        [14:0] voxel_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] voxel_value;
    } out_t;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [31:0] inv_cell_size;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/tvs_apb_regs.sv
// ----------------------------------------------------------------------------
// tvs_apb_regs
// APB register file holding the grid origin and reciprocal cell size.
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_apb_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tvs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output tvs_pkg::cfg_t                     cfg
);

    tvs_pkg::cfg_t    cfg_reg;
    tvs_pkg::reg_idx_t idx;

    assign idx    = tvs_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.origin_z      <= '0;
            cfg_reg.inv_cell_size <= tvs_pkg::INV_CELL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                tvs_pkg::REG_ORIGIN_X: cfg_reg.origin_x      <= pwdata;
                tvs_pkg::REG_ORIGIN_Y: cfg_reg.origin_y      <= pwdata;
                tvs_pkg::REG_ORIGIN_Z: cfg_reg.origin_z      <= pwdata;
                tvs_pkg::REG_INV_CELL: cfg_reg.inv_cell_size <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tvs_pkg::REG_ORIGIN_X: prdata = cfg_reg.origin_x;
            tvs_pkg::REG_ORIGIN_Y: prdata = cfg_reg.origin_y;
            tvs_pkg::REG_ORIGIN_Z: prdata = cfg_reg.origin_z;
            tvs_pkg::REG_INV_CELL: prdata = cfg_reg.inv_cell_size;
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/trilinear_voxel_splat.sv
// ----------------------------------------------------------------------------
// trilinear_voxel_splat
// Trilinear splatting of weighted points into a saturating 48-bit voxel grid.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_valid / s_ready    tvs_pkg::in_t  (splat or read beat)
//  m_*       out   m_valid / m_ready    tvs_pkg::out_t (status, voxel value)
//  apb       in    psel/penable/pready  origin x/y/z, inv_cell_size
//
//  A splat steps through the idle state, 3 axis multiplies on the shared
//  32x32 unit, the check and base states, 8 corner issues into the
//  read-modify-write pipe on the grid memory, a drain of that pipe and the
//  result load. A read goes through the read and read-data states; a rejected
//  point skips the corners after the check. After reset the grid is cleared
//  one entry a cycle with s_ready low. A result beat waits in the output
//  register; the next beat is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_voxel_splat #(
    parameter int unsigned GRID_X = 32,
    parameter int unsigned GRID_Y = 32,
    parameter int unsigned GRID_Z = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire tvs_pkg::in_t                 s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output tvs_pkg::out_t                     m_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tvs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int unsigned VOXELS = GRID_X * GRID_Y * GRID_Z;
    localparam int unsigned AW     = $clog2(VOXELS);
    localparam int unsigned GXY    = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int unsigned GMAX   = (GXY > GRID_Z) ? GXY : GRID_Z;
    localparam int unsigned CW     = $clog2(GMAX);

    localparam logic [31:0]   LIM_X  = 32'(GRID_X - 2);
    localparam logic [31:0]   LIM_Y  = 32'(GRID_Y - 2);
    localparam logic [31:0]   LIM_Z  = 32'(GRID_Z - 2);
    localparam logic [31:0]   VOX32  = 32'(VOXELS);
    localparam logic [AW-1:0] LAST   = AW'(VOXELS - 1);
    localparam logic [AW-1:0] OFF_X  = AW'(1);
    localparam logic [AW-1:0] OFF_Y  = AW'(GRID_X);
    localparam logic [AW-1:0] OFF_Z  = AW'(GRID_X * GRID_Y);
    localparam logic [47:0]   MAX48  = '1;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_AXIS   = 10'b00_0000_0100,
        S_EVWAIT = 10'b00_0000_1000,
        S_BASE   = 10'b00_0001_0000,
        S_CORNER = 10'b00_0010_0000,
        S_DRAIN  = 10'b00_0100_0000,
        S_READ   = 10'b00_1000_0000,
        S_RDATA  = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

    tvs_pkg::cfg_t cfg;

    tvs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    logic [AW-1:0]      clr_cnt_reg;
    logic [1:0]         ax_reg;
    logic [1:0]         ev_ax_reg;
    logic               ev_v_reg;
    logic               neg_reg;
    logic               bad_reg;
    logic [2:0]         k_reg;
    logic               v0_reg, v1_reg, v2_reg;
    logic               m_valid_reg;

    tvs_pkg::in_t       in_reg;
    logic signed [32:0] d_reg [3];
    logic [63:0]        prod_reg;
    logic [CW-1:0]      cell_reg [3];
    logic [15:0]        frac_reg [3];
    logic [AW-1:0]      base_reg;
    logic [33:0]        wxy_reg;
    logic [16:0]        wz_reg;
    logic [48:0]        w_reg;
    logic [56:0]        hi_reg;
    logic [55:0]        lo_reg;
    logic [47:0]        old_reg;
    logic [AW-1:0]      a0_reg, a1_reg, a2_reg;
    logic [1:0]         res_status_reg;
    logic [47:0]        res_value_reg;
    tvs_pkg::out_t      out_reg;

    logic [47:0]        mem [VOXELS];
    logic [47:0]        rd_q;

    logic               accept;
    logic               out_load;
    logic [31:0]        u_sel;
    logic [63:0]        prod_c;
    logic [31:0]        cell_w;
    logic [31:0]        lim_sel;
    logic               ev_bad;
    logic [16:0]        wx, wy, wz;
    logic [AW-1:0]      corner_off;
    logic [31:0]        base32;
    logic [31:0]        idx32;
    logic               in_range;
    logic [57:0]        acc_sum;
    logic [33:0]        add_c;
    logic [49:0]        sum_c;
    logic [47:0]        sat_c;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [47:0]        wr_data;

    function automatic logic [16:0] axis_w(input logic hi, input logic [15:0] f);
        axis_w = hi ? {1'b0, f} : (17'h1_0000 - {1'b0, f});
    endfunction

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // axis mapping: one axis per cycle through the shared multiplier
    assign u_sel  = d_reg[ax_reg][31:0];
    assign prod_c = u_sel * cfg.inv_cell_size;
    assign cell_w = prod_reg[63:32];

    always_comb begin
        case (ev_ax_reg)
            2'd0:    lim_sel = LIM_X;
            2'd1:    lim_sel = LIM_Y;
            default: lim_sel = LIM_Z;
        endcase
    end

    assign ev_bad = neg_reg || (cell_w > lim_sel);

    assign wx = axis_w(k_reg[0], frac_reg[0]);
    assign wy = axis_w(k_reg[1], frac_reg[1]);
    assign wz = axis_w(k_reg[2], frac_reg[2]);

    assign corner_off = (k_reg[0] ? OFF_X : '0) + (k_reg[1] ? OFF_Y : '0)
                      + (k_reg[2] ? OFF_Z : '0);

    assign base32 = 32'(cell_reg[0])
                  + 32'(GRID_X) * (32'(cell_reg[1]) + 32'(GRID_Y) * 32'(cell_reg[2]));

    assign idx32    = {17'b0, in_reg.voxel_index};
    assign in_range = idx32 < VOX32;

    // final corner accumulate with saturation
    assign acc_sum = 58'(hi_reg) + 58'(lo_reg[55:24]);
    assign add_c   = acc_sum[57:24];
    assign sum_c   = 50'(old_reg) + 50'(add_c);
    assign sat_c   = (sum_c > 50'(MAX48)) ? MAX48 : sum_c[47:0];

    assign wr_en   = (state_reg == S_CLEAR) || v2_reg;
    assign wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : a2_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : sat_c;
    assign rd_en   = v0_reg || ((state_reg == S_READ) && in_range);
    assign rd_addr = (state_reg == S_READ) ? idx32[AW-1:0] : a0_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_cnt_reg == LAST) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.kind == tvs_pkg::KIND_READ) ? S_READ : S_AXIS;
                end
            end
            S_AXIS:   if (ax_reg == 2'd2) state_next = S_EVWAIT;
            S_EVWAIT: state_next = S_BASE;
            S_BASE:   state_next = bad_reg ? S_FINISH : S_CORNER;
            S_CORNER: if (k_reg == 3'd7) state_next = S_DRAIN;
            S_DRAIN:  if (!v0_reg && !v1_reg && !v2_reg) state_next = S_FINISH;
            S_READ:   state_next = S_RDATA;
            S_RDATA:  state_next = S_FINISH;
            S_FINISH: if (out_load) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ax_reg      <= '0;
            ev_v_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            k_reg       <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept) begin
                ax_reg  <= '0;
                k_reg   <= '0;
                bad_reg <= 1'b0;
            end
            if (state_reg == S_AXIS) begin
                ax_reg <= ax_reg + 1'b1;
            end
            ev_v_reg <= (state_reg == S_AXIS);
            if (ev_v_reg && ev_bad) begin
                bad_reg <= 1'b1;
            end
            if (state_reg == S_CORNER) begin
                k_reg <= k_reg + 1'b1;
            end
            v0_reg <= (state_reg == S_CORNER);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg   <= s_data;
            d_reg[0] <= 33'(s_data.pos_x) - 33'(signed'(cfg.origin_x));
            d_reg[1] <= 33'(s_data.pos_y) - 33'(signed'(cfg.origin_y));
            d_reg[2] <= 33'(s_data.pos_z) - 33'(signed'(cfg.origin_z));
        end
        if (state_reg == S_AXIS) begin
            prod_reg  <= prod_c;
            neg_reg   <= d_reg[ax_reg][32];
            ev_ax_reg <= ax_reg;
        end
        if (ev_v_reg) begin
            cell_reg[ev_ax_reg] <= cell_w[CW-1:0];
            frac_reg[ev_ax_reg] <= prod_reg[31:16];
        end
        if (state_reg == S_BASE) begin
            base_reg       <= base32[AW-1:0];
            res_status_reg <= bad_reg ? tvs_pkg::ST_OUTSIDE : tvs_pkg::ST_SPLAT;
            res_value_reg  <= '0;
        end
        // corner pipe: weight, read, scale, write back
        wxy_reg <= 34'(wx) * 34'(wy);
        wz_reg  <= wz;
        a0_reg  <= base_reg + corner_off;
        w_reg   <= 49'(wxy_reg) * 49'(wz_reg);
        a1_reg  <= a0_reg;
        hi_reg  <= in_reg.density * w_reg[48:24];
        lo_reg  <= in_reg.density * w_reg[23:0];
        old_reg <= rd_q;
        a2_reg  <= a1_reg;
        if (state_reg == S_RDATA) begin
            res_status_reg <= tvs_pkg::ST_READ;
            res_value_reg  <= in_range ? rd_q : '0;
        end
        if (out_load) begin
            out_reg.status      <= res_status_reg;
            out_reg.voxel_value <= res_value_reg;
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("beat taken while previous item still at work");

    a_write_in_splat: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (state_reg == S_CORNER || state_reg == S_DRAIN))
        else $error("corner write outside of a splat");

    a_splat_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != tvs_pkg::ST_READ) |-> (m_data.voxel_value == '0))
        else $error("nonzero value on a splat result");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!m_valid && !v0_reg && !v1_reg && !v2_reg))
        else $error("activity during grid clear");

endmodule

`default_nettype wire
